// ===== hw/rtl/sap_pkg.sv =====
// Shared types, constants and the sine magnitude function of the stereo auto-panner.
package sap_pkg;

   // CSR map: register index = paddr[3:2]
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_IDX_BITS  = 2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DRIFT_STEP   = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PHASE_OFFSET = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PAN_LAW_GAIN = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WET_MIX      = 2'd3;

   typedef struct packed {
      logic [31:0] drift_step;
      logic [15:0] phase_offset;
      logic [16:0] pan_law_gain;
      logic [16:0] wet_mix;
   } csr_type;

   // Q1.16 unity and CSR reset values
   localparam int UNITY_BITS = 17;
   localparam logic [UNITY_BITS-1:0] UNITY_Q16 = 17'd65536;
   localparam logic [31:0] DRIFT_RESET  = 32'd0;
   localparam logic [15:0] OFFSET_RESET = 16'd32768;

   // LFO state: phase Q1.32 turns, speed Q19.25, xorshift noise word
   localparam int PHASE_BITS = 33;
   localparam int SPEED_BITS = 44;
   localparam int SPEED_FRAC = 25;
   localparam logic [PHASE_BITS-1:0] ONE_TURN    = 33'h1_0000_0000;
   localparam logic [PHASE_BITS-1:0] PHASE_RESET = 33'd2050695827;
   localparam logic [SPEED_BITS-1:0] SPEED_RESET = 44'd14411518804230;
   localparam logic [SPEED_BITS-1:0] RELOAD_BASE = 44'd14411519;
   localparam logic [23:0]           RELOAD_MUL  = 24'd8906319;
   localparam logic [31:0]           NOISE_SEED  = 32'd2463534242;

   // Fixed-point shifts in the mix path
   localparam int GAIN_FRAC = 14;
   localparam int MIX_FRAC  = 16;
   localparam int OUT_FRAC  = 20;
   localparam int DRY_SHIFT = 4;

   // Queue depths
   localparam int MID_DEPTH      = 2;
   localparam int OUT_DEPTH      = 8;
   localparam int OUT_COUNT_BITS = $clog2(OUT_DEPTH + 1);

   // Front sequencer states
   typedef enum logic [1:0] {
      FR_IDLE,
      FR_MULT,
      FR_UPDATE
   } front_state_type;

   // Q30 sine polynomial coefficients (odd Taylor terms to x^9)
   localparam logic [63:0] SIN_C1 = 64'd1686629713;
   localparam logic [63:0] SIN_C3 = 64'd693598668;
   localparam logic [63:0] SIN_C5 = 64'd85569306;
   localparam logic [63:0] SIN_C7 = 64'd5026995;
   localparam logic [63:0] SIN_C9 = 64'd172272;

   // Sine magnitude in Q1.16 for quarter-wave index idx of a 2^table_bits table.
   // Evaluated at elaboration to fill the ROM.
   function automatic logic [UNITY_BITS-1:0] sine_mag(int table_bits, int idx);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] p;
      logic [63:0] r;
      logic [63:0] m;
      x  = 64'(idx) << (32 - table_bits);
      x2 = (x * x) >> 30;
      p  = SIN_C9;
      p  = SIN_C7 - ((x2 * p) >> 30);
      p  = SIN_C5 - ((x2 * p) >> 30);
      p  = SIN_C3 - ((x2 * p) >> 30);
      p  = SIN_C1 - ((x2 * p) >> 30);
      r  = (x * p) >> 30;
      m  = (r + 64'd8192) >> 14;
      if (m > 64'(UNITY_Q16)) begin
         m = 64'(UNITY_Q16);
      end
      return m[UNITY_BITS-1:0];
   endfunction

endpackage

// ===== hw/rtl/sap_fifo.sv =====
// Small register-based queue used between front and back and on the result side.
module sap_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  logic [WIDTH-1:0]             push_data,
   output logic                         full,
   input  logic                         pop,
   output logic [WIDTH-1:0]             pop_data,
   output logic                         empty,
   output logic [$clog2(DEPTH+1)-1:0]   count
);

   localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW   = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTRW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTRW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign count    = count_ff;
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // pointer wrap and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/sap_front.sv =====
// Front end: takes sample pairs, advances the LFO phase/speed/noise, queues angles.
module sap_front #(
   parameter int SAMPLE_BITS     = 24,
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  sap_pkg::csr_type                            csr,
   input  logic                                        push,
   output logic                                        full,
   input  logic signed [SAMPLE_BITS-1:0]               left_in,
   input  logic signed [SAMPLE_BITS-1:0]               right_in,
   output logic                                        q_push,
   output logic [2*SAMPLE_BITS+2*SINE_TABLE_BITS-1:0]  q_data,
   input  logic                                        q_full
);

   localparam int S    = SAMPLE_BITS;
   localparam int B    = SINE_TABLE_BITS;
   localparam int PB   = sap_pkg::PHASE_BITS;
   localparam int SB   = sap_pkg::SPEED_BITS;
   localparam int SF   = sap_pkg::SPEED_FRAC;
   localparam int HIW  = SB - SF;          // integer part of speed
   localparam int PHW  = HIW + 32;         // high partial product
   localparam int PLW  = SF + 32;          // low partial product
   localparam int INCW = PHW + 1;          // increment / new phase sum
   localparam int RLW  = 32 + 24;          // reload product
   localparam int RKW  = RLW - 31;         // reload product above bit 30

   sap_pkg::front_state_type state_ff, state_in;

   logic [PB-1:0]  phase_ff, phase_in;
   logic [SB-1:0]  speed_ff, speed_in;
   logic [31:0]    noise_ff, noise_in;
   logic [S-1:0]   left_ff, right_ff;
   logic [PHW-1:0] prod_hi_ff;
   logic [31:0]    prod_lo_ff;
   logic [RKW-1:0] reload_ff;

   logic           accept;
   logic           advance;
   logic [PLW-1:0] prod_lo_full;
   logic [RLW-1:0] reload_full;
   logic [INCW-1:0] inc, phase_sum;
   logic           wrap;
   logic [RKW:0]   reload_rnd;
   logic [31:0]    nx1, nx2;
   logic [31:0]    angle_l, angle_r;

   assign accept  = push && !full;
   assign advance = (state_ff == sap_pkg::FR_UPDATE) && !q_full;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sap_pkg::FR_IDLE: begin
            if (accept) state_in = sap_pkg::FR_MULT;
         end
         sap_pkg::FR_MULT: begin
            state_in = sap_pkg::FR_UPDATE;
         end
         sap_pkg::FR_UPDATE: begin
            if (!q_full) state_in = accept ? sap_pkg::FR_MULT : sap_pkg::FR_IDLE;
         end
         default: begin
            state_in = sap_pkg::FR_IDLE;
         end
      endcase
   end

   // handshake outputs; a new pair may enter in the cycle the previous one is queued
   always_comb begin
      full   = 1'b1;
      q_push = 1'b0;
      case (state_ff)
         sap_pkg::FR_IDLE: begin
            full = 1'b0;
         end
         sap_pkg::FR_MULT: begin
            full = 1'b1;
         end
         sap_pkg::FR_UPDATE: begin
            full   = q_full;
            q_push = !q_full;
         end
         default: begin
            full = 1'b1;
         end
      endcase
   end

   // phase increment = speed * drift, split at the binary point
   assign prod_lo_full = PLW'(speed_ff[SF-1:0]) * PLW'(csr.drift_step);
   assign reload_full  = RLW'(noise_ff) * RLW'(sap_pkg::RELOAD_MUL);

   always_ff @(posedge clock) begin
      prod_hi_ff <= PHW'(speed_ff[SB-1:SF]) * PHW'(csr.drift_step);
      prod_lo_ff <= prod_lo_full[PLW-1:SF];
      reload_ff  <= reload_full[RLW-1:31];
      if (accept) begin
         left_ff  <= left_in;
         right_ff <= right_in;
      end
   end

   // phase advance with wrap; speed reload rounds the noise product
   always_comb begin
      inc        = INCW'(prod_hi_ff) + INCW'(prod_lo_ff);
      phase_sum  = inc + INCW'(phase_ff);
      wrap       = phase_sum > INCW'(sap_pkg::ONE_TURN);
      reload_rnd = {1'b0, reload_ff} + 1'b1;
      phase_in   = wrap ? '0 : phase_sum[PB-1:0];
      speed_in   = wrap ? sap_pkg::RELOAD_BASE + SB'(reload_rnd[RKW:1]) : speed_ff;
      nx1        = noise_ff ^ (noise_ff << 13);
      nx2        = nx1 ^ (nx1 >> 17);
      noise_in   = nx2 ^ (nx2 << 5);
      angle_l    = phase_in[31:0];
      angle_r    = angle_l + {csr.phase_offset, 16'b0};
   end

   assign q_data = {left_ff, right_ff, angle_l[31:32-B], angle_r[31:32-B]};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sap_pkg::FR_IDLE;
         phase_ff <= sap_pkg::PHASE_RESET;
         speed_ff <= sap_pkg::SPEED_RESET;
         noise_ff <= sap_pkg::NOISE_SEED;
      end else begin
         state_ff <= state_in;
         if (advance) begin
            phase_ff <= phase_in;
            speed_ff <= speed_in;
            noise_ff <= noise_in;
         end
      end
   end

   // phase never rests beyond one turn
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= sap_pkg::ONE_TURN)
      else $error("LFO phase beyond one turn");

   // xorshift from a nonzero seed never reaches zero
   a_noise_nonzero: assert property (@(posedge clock) disable iff (reset)
      noise_ff != '0)
      else $error("noise word collapsed to zero");

   // a blocked update holds the LFO state
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sap_pkg::FR_UPDATE && q_full)
      |=> (state_ff == sap_pkg::FR_UPDATE && $stable(phase_ff) && $stable(noise_ff)))
      else $error("LFO state moved while queue full");

endmodule

// ===== hw/rtl/sap_back.sv =====
// Back end: sine ROM lookup, gain, mid/side recombine, dry/wet mix and saturation.
module sap_back #(
   parameter int SAMPLE_BITS     = 24,
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  sap_pkg::csr_type                            csr,
   input  logic [2*SAMPLE_BITS+2*SINE_TABLE_BITS-1:0]  q_data,
   input  logic                                        q_empty,
   output logic                                        q_pop,
   input  logic [sap_pkg::OUT_COUNT_BITS-1:0]          out_count,
   input  logic                                        out_full,
   output logic                                        out_push,
   output logic [2*SAMPLE_BITS-1:0]                    out_data
);

   localparam int S       = SAMPLE_BITS;
   localparam int B       = SINE_TABLE_BITS;
   localparam int UB      = sap_pkg::UNITY_BITS;
   localparam int QUARTER = 1 << (B - 2);
   localparam int IW      = B - 1;                     // ROM index, 0..QUARTER
   localparam int NST     = 5;                         // pipeline stages
   localparam int CW      = sap_pkg::OUT_COUNT_BITS + 1;
   localparam int XPW     = S + UB + 2;                // sample * gain
   localparam int PW      = XPW - sap_pkg::GAIN_FRAC;  // scaled channel
   localparam int DW      = S + UB + 1;                // sample * (1 - wet)
   localparam int SW      = PW + 1;                    // sum / difference
   localparam int MW      = SW + UB + 1;               // mid
   localparam int SDW     = SW + sap_pkg::MIX_FRAC;    // side
   localparam int TW      = MW + 1;                    // mid +/- side
   localparam int WW      = TW - sap_pkg::MIX_FRAC;    // wet channel
   localparam int WPW     = WW + UB + 1;               // wet * mix
   localparam int DSW     = DW + sap_pkg::DRY_SHIFT;   // dry term
   localparam int AW      = WPW + 1;                   // accumulator
   localparam int QW      = AW - sap_pkg::OUT_FRAC;    // rounded

   // quarter-wave sine ROM, read at both angles
   logic [UB-1:0] sine_rom [QUARTER+1];
   for (genvar gi = 0; gi <= QUARTER; gi++) begin : g_rom
      assign sine_rom[gi] = sap_pkg::sine_mag(B, gi);
   end

   logic [NST-1:0] vld_ff, vld_in;
   logic [CW-1:0]  reserve;
   logic [UB-1:0]  pan_c, wet_c, dry_c;

   logic [S-1:0]   hd_left, hd_right;
   logic [B-1:0]   hd_kl, hd_kr;
   logic [IW-1:0]  idx_l, idx_r;

   logic signed [S-1:0]   s1_x_l_ff, s1_x_r_ff;
   logic [UB-1:0]         s1_mag_l_ff, s1_mag_r_ff;
   logic                  s1_neg_l_ff, s1_neg_r_ff;
   logic signed [PW-1:0]  s2_p_l_ff, s2_p_r_ff;
   logic signed [DW-1:0]  s2_dry_l_ff, s2_dry_r_ff;
   logic signed [MW-1:0]  s3_mid_ff;
   logic [SW-1:0]         s3_diff_ff;
   logic signed [DW-1:0]  s3_dry_l_ff, s3_dry_r_ff;
   logic signed [WW-1:0]  s4_w_l_ff, s4_w_r_ff;
   logic signed [DW-1:0]  s4_dry_l_ff, s4_dry_r_ff;
   logic [AW-1:0]         s5_acc_l_ff, s5_acc_r_ff;

   logic [UB:0]           g_l, g_r;
   logic signed [XPW-1:0] xp_l, xp_r;
   logic signed [DW-1:0]  dry_l_in, dry_r_in;
   logic [SW-1:0]         sum_lr, diff_in;
   logic signed [MW-1:0]  mid_in;
   logic [SDW-1:0]        side;
   logic [TW-1:0]         tot_l, tot_r;
   logic signed [WPW-1:0] wp_l, wp_r;
   logic [DSW-1:0]        dsh_l, dsh_r;
   logic [AW-1:0]         acc_l_in, acc_r_in;
   logic [AW-1:0]         rnd_l, rnd_r;
   logic [S-1:0]          sat_l, sat_r;

   // clamp the Q1.16 controls at unity
   assign pan_c = (csr.pan_law_gain > sap_pkg::UNITY_Q16) ? sap_pkg::UNITY_Q16
                                                          : csr.pan_law_gain;
   assign wet_c = (csr.wet_mix > sap_pkg::UNITY_Q16) ? sap_pkg::UNITY_Q16 : csr.wet_mix;
   assign dry_c = sap_pkg::UNITY_Q16 - wet_c;

   // take an item only when its result has a reserved slot in the result queue
   assign reserve = CW'(out_count) + CW'($countones(vld_ff));
   assign q_pop   = !q_empty && (reserve < CW'(sap_pkg::OUT_DEPTH));
   assign vld_in  = {vld_ff[NST-2:0], q_pop};

   // quarter-wave addressing: odd quadrants mirror
   assign {hd_left, hd_right, hd_kl, hd_kr} = q_data;
   assign idx_l = hd_kl[B-2] ? IW'(QUARTER) - IW'(hd_kl[B-3:0]) : IW'(hd_kl[B-3:0]);
   assign idx_r = hd_kr[B-2] ? IW'(QUARTER) - IW'(hd_kr[B-3:0]) : IW'(hd_kr[B-3:0]);

   // stage 1: ROM read
   always_ff @(posedge clock) begin
      s1_mag_l_ff <= sine_rom[idx_l];
      s1_mag_r_ff <= sine_rom[idx_r];
      s1_neg_l_ff <= hd_kl[B-1];
      s1_neg_r_ff <= hd_kr[B-1];
      s1_x_l_ff   <= hd_left;
      s1_x_r_ff   <= hd_right;
   end

   // stage 2: gains 1 +/- sin, scaled channels and dry terms
   always_comb begin
      g_l = s1_neg_l_ff ? {1'b0, sap_pkg::UNITY_Q16} - {1'b0, s1_mag_l_ff}
                        : {1'b0, sap_pkg::UNITY_Q16} + {1'b0, s1_mag_l_ff};
      g_r = s1_neg_r_ff ? {1'b0, sap_pkg::UNITY_Q16} - {1'b0, s1_mag_r_ff}
                        : {1'b0, sap_pkg::UNITY_Q16} + {1'b0, s1_mag_r_ff};
      xp_l     = s1_x_l_ff * $signed({1'b0, g_l});
      xp_r     = s1_x_r_ff * $signed({1'b0, g_r});
      dry_l_in = s1_x_l_ff * $signed({1'b0, dry_c});
      dry_r_in = s1_x_r_ff * $signed({1'b0, dry_c});
   end

   always_ff @(posedge clock) begin
      s2_p_l_ff   <= xp_l[XPW-1:sap_pkg::GAIN_FRAC];
      s2_p_r_ff   <= xp_r[XPW-1:sap_pkg::GAIN_FRAC];
      s2_dry_l_ff <= dry_l_in;
      s2_dry_r_ff <= dry_r_in;
   end

   // stage 3: mid weighted by pan law, side kept as difference
   always_comb begin
      sum_lr  = {s2_p_l_ff[PW-1], s2_p_l_ff} + {s2_p_r_ff[PW-1], s2_p_r_ff};
      diff_in = {s2_p_l_ff[PW-1], s2_p_l_ff} - {s2_p_r_ff[PW-1], s2_p_r_ff};
      mid_in  = $signed(sum_lr) * $signed({1'b0, pan_c});
   end

   always_ff @(posedge clock) begin
      s3_mid_ff   <= mid_in;
      s3_diff_ff  <= diff_in;
      s3_dry_l_ff <= s2_dry_l_ff;
      s3_dry_r_ff <= s2_dry_r_ff;
   end

   // stage 4: recombine mid/side and drop the Q16 fraction
   always_comb begin
      side  = {s3_diff_ff, {sap_pkg::MIX_FRAC{1'b0}}};
      tot_l = {s3_mid_ff[MW-1], s3_mid_ff} + {{(TW-SDW){side[SDW-1]}}, side};
      tot_r = {s3_mid_ff[MW-1], s3_mid_ff} - {{(TW-SDW){side[SDW-1]}}, side};
   end

   always_ff @(posedge clock) begin
      s4_w_l_ff   <= tot_l[TW-1:sap_pkg::MIX_FRAC];
      s4_w_r_ff   <= tot_r[TW-1:sap_pkg::MIX_FRAC];
      s4_dry_l_ff <= s3_dry_l_ff;
      s4_dry_r_ff <= s3_dry_r_ff;
   end

   // stage 5: wet/dry mix
   always_comb begin
      wp_l     = s4_w_l_ff * $signed({1'b0, wet_c});
      wp_r     = s4_w_r_ff * $signed({1'b0, wet_c});
      dsh_l    = {s4_dry_l_ff, {sap_pkg::DRY_SHIFT{1'b0}}};
      dsh_r    = {s4_dry_r_ff, {sap_pkg::DRY_SHIFT{1'b0}}};
      acc_l_in = {wp_l[WPW-1], wp_l} + {{(AW-DSW){dsh_l[DSW-1]}}, dsh_l};
      acc_r_in = {wp_r[WPW-1], wp_r} + {{(AW-DSW){dsh_r[DSW-1]}}, dsh_r};
   end

   always_ff @(posedge clock) begin
      s5_acc_l_ff <= acc_l_in;
      s5_acc_r_ff <= acc_r_in;
   end

   // round half up on the Q20 fraction, then saturate
   always_comb begin
      rnd_l = s5_acc_l_ff + {{(QW){1'b0}}, 1'b1, {(sap_pkg::OUT_FRAC-1){1'b0}}};
      rnd_r = s5_acc_r_ff + {{(QW){1'b0}}, 1'b1, {(sap_pkg::OUT_FRAC-1){1'b0}}};
      if (rnd_l[AW-1:S-1+sap_pkg::OUT_FRAC] == '0 ||
          rnd_l[AW-1:S-1+sap_pkg::OUT_FRAC] == '1) begin
         sat_l = rnd_l[S-1+sap_pkg::OUT_FRAC:sap_pkg::OUT_FRAC];
      end else begin
         sat_l = rnd_l[AW-1] ? {1'b1, {(S-1){1'b0}}} : {1'b0, {(S-1){1'b1}}};
      end
      if (rnd_r[AW-1:S-1+sap_pkg::OUT_FRAC] == '0 ||
          rnd_r[AW-1:S-1+sap_pkg::OUT_FRAC] == '1) begin
         sat_r = rnd_r[S-1+sap_pkg::OUT_FRAC:sap_pkg::OUT_FRAC];
      end else begin
         sat_r = rnd_r[AW-1] ? {1'b1, {(S-1){1'b0}}} : {1'b0, {(S-1){1'b1}}};
      end
   end

   assign out_push = vld_ff[NST-1];
   assign out_data = {sat_l, sat_r};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // the reservation guarantees the result queue never overflows
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full)
      else $error("result pushed into a full queue");

   a_reserve_bound: assert property (@(posedge clock) disable iff (reset)
      reserve <= CW'(sap_pkg::OUT_DEPTH))
      else $error("more results in flight than result queue slots");

endmodule

// ===== hw/rtl/stereo_auto_panner_top.sv =====
// Top level of the stereo auto-panner: CSR block, front end, queues and back end.
//
// Usage: sample pairs enter on req_left_in/req_right_in; a pair transfers on a
// clock edge with push high and full low. Panned pairs leave on rsp_left_out/
// rsp_right_out; the oldest result is shown while empty is low and transfers on
// an edge with pop high. Exactly one result comes back per input pair, in order.
// The front end takes a new pair only after the LFO update loop for the previous
// pair (speed*drift multiply, then phase add/wrap) has finished, so that the next
// pair uses the new speed; it also holds while the inner queue is full. The back
// end is a 5-stage pipeline. The APB-style CSR port (drift_step, phase_offset,
// pan_law_gain, wet_mix at byte addresses 0, 4, 8, 12) must be written by the
// user only while the block is idle; the block itself does not enforce this.
// Reset (synchronous) loads the LFO phase, speed and noise seed, sets CSR defaults
// and empties both queues. When the receiver stalls, up to 8 results wait in the
// result queue, then 2 pairs in the inner queue and one in the front end, then
// full stays high.
module stereo_auto_panner_top #(
   parameter int SAMPLE_BITS     = 24,
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // input channel
   input  logic                                  push,
   output logic                                  full,
   input  logic signed [SAMPLE_BITS-1:0]         req_left_in,
   input  logic signed [SAMPLE_BITS-1:0]         req_right_in,
   // result channel
   output logic                                  empty,
   input  logic                                  pop,
   output logic signed [SAMPLE_BITS-1:0]         rsp_left_out,
   output logic signed [SAMPLE_BITS-1:0]         rsp_right_out,
   // CSR port
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [sap_pkg::CSR_ADDR_BITS-1:0]     paddr,
   input  logic [31:0]                           pwdata,
   output logic [31:0]                           prdata,
   output logic                                  pready
);

   localparam int QW = 2 * SAMPLE_BITS + 2 * SINE_TABLE_BITS;
   localparam int OW = 2 * SAMPLE_BITS;

   sap_pkg::csr_type csr_ff, csr_in;
   logic [sap_pkg::CSR_IDX_BITS-1:0] csr_idx;
   logic csr_wr;

   logic          q_push, q_full, q_pop, q_empty;
   logic [QW-1:0] q_wdata, q_rdata;
   logic [$clog2(sap_pkg::MID_DEPTH+1)-1:0] q_count;
   logic          o_push, o_full;
   logic [OW-1:0] o_wdata, o_rdata;
   logic [sap_pkg::OUT_COUNT_BITS-1:0] o_count;

   // CSR write transfer and readback
   assign pready  = 1'b1;
   assign csr_idx = paddr[sap_pkg::CSR_ADDR_BITS-1:2];
   assign csr_wr  = psel && penable && pwrite && pready;

   always_comb begin
      csr_in = csr_ff;
      prdata = '0;
      case (csr_idx)
         sap_pkg::CSR_DRIFT_STEP: begin
            prdata = csr_ff.drift_step;
            if (csr_wr) csr_in.drift_step = pwdata;
         end
         sap_pkg::CSR_PHASE_OFFSET: begin
            prdata = 32'(csr_ff.phase_offset);
            if (csr_wr) csr_in.phase_offset = pwdata[15:0];
         end
         sap_pkg::CSR_PAN_LAW_GAIN: begin
            prdata = 32'(csr_ff.pan_law_gain);
            if (csr_wr) csr_in.pan_law_gain = pwdata[16:0];
         end
         sap_pkg::CSR_WET_MIX: begin
            prdata = 32'(csr_ff.wet_mix);
            if (csr_wr) csr_in.wet_mix = pwdata[16:0];
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.drift_step   <= sap_pkg::DRIFT_RESET;
         csr_ff.phase_offset <= sap_pkg::OFFSET_RESET;
         csr_ff.pan_law_gain <= sap_pkg::UNITY_Q16;
         csr_ff.wet_mix      <= sap_pkg::UNITY_Q16;
      end else begin
         csr_ff <= csr_in;
      end
   end

   sap_front #(
      .SAMPLE_BITS     (SAMPLE_BITS),
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .csr      (csr_ff),
      .push     (push),
      .full     (full),
      .left_in  (req_left_in),
      .right_in (req_right_in),
      .q_push   (q_push),
      .q_data   (q_wdata),
      .q_full   (q_full)
   );

   sap_fifo #(
      .WIDTH (QW),
      .DEPTH (sap_pkg::MID_DEPTH)
   ) u_mid_q (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .empty     (q_empty),
      .count     (q_count)
   );

   sap_back #(
      .SAMPLE_BITS     (SAMPLE_BITS),
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr_ff),
      .q_data    (q_rdata),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .out_count (o_count),
      .out_full  (o_full),
      .out_push  (o_push),
      .out_data  (o_wdata)
   );

   sap_fifo #(
      .WIDTH (OW),
      .DEPTH (sap_pkg::OUT_DEPTH)
   ) u_out_q (
      .clock     (clock),
      .reset     (reset),
      .push      (o_push),
      .push_data (o_wdata),
      .full      (o_full),
      .pop       (pop),
      .pop_data  (o_rdata),
      .empty     (empty),
      .count     (o_count)
   );

   assign rsp_left_out  = o_rdata[OW-1:SAMPLE_BITS];
   assign rsp_right_out = o_rdata[SAMPLE_BITS-1:0];

   // inner queue never holds more than its depth
   a_mid_count: assert property (@(posedge clock) disable iff (reset)
      q_count <= ($clog2(sap_pkg::MID_DEPTH+1))'(sap_pkg::MID_DEPTH))
      else $error("inner queue count out of range");

endmodule
